### hdl/msl_pkg.sv
// Shared types, codes and constants for the multichannel servo slew limiter.
package msl_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 8;

   localparam int OP_W   = 3;
   localparam int PIN_W  = 6;
   localparam int POS_W  = 8;
   localparam int SPD_W  = 4;
   localparam int SLOT_W = 3;
   localparam int STAT_W = 2;
   localparam int TIME_W = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD        = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_POS    = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_TARGET = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_PIN = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd2;

   localparam logic REG_STEP_INTERVAL = 1'b0;

   localparam logic [TIME_W-1:0] STEP_INTERVAL_RESET = 16'd15;
   localparam logic [SPD_W-1:0]  NEW_CHANNEL_SPEED   = 4'd1;

   typedef struct packed {
      logic [PIN_W-1:0] pin;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] target;
      logic [SPD_W-1:0] speed;
      logic [POS_W-1:0] min;
      logic [POS_W-1:0] max;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_READ,
      ST_EVAL
   } state_type;

endpackage

### hdl/msl_move.sv
// Slew step unit: moves one channel by its speed toward its target within its limits.
module msl_move (
   input  msl_pkg::entry_type        entry,
   output logic [msl_pkg::POS_W-1:0] new_position
);
   import msl_pkg::*;

   logic [POS_W:0] pos_ext;
   logic [POS_W:0] up_sum;
   logic [POS_W:0] tgt_sum;
   logic [POS_W:0] low_sum;
   logic           hold;

   assign pos_ext = (POS_W+1)'(entry.position);
   assign up_sum  = pos_ext + (POS_W+1)'(entry.speed);
   assign tgt_sum = (POS_W+1)'(entry.target) + (POS_W+1)'(entry.speed);
   assign low_sum = (POS_W+1)'(entry.min) + (POS_W+1)'(entry.speed);
   assign hold    = (pos_ext < tgt_sum) && (up_sum > (POS_W+1)'(entry.target));

   always_comb begin
      new_position = entry.position;
      if (!hold) begin
         if (entry.position < entry.target) begin
            if (up_sum >= (POS_W+1)'(entry.max)) begin
               new_position = entry.max;
            end else begin
               new_position = up_sum[POS_W-1:0];
            end
         end else if (entry.position > entry.target) begin
            if (pos_ext <= low_sum) begin
               new_position = entry.min;
            end else begin
               new_position = entry.position - POS_W'(entry.speed);
            end
         end
      end
   end

endmodule

### hdl/multi_servo_slew_limiter_unit.sv
// Top level of the multichannel servo slew limiter: sequencer, channel table and CSR.
// An add goes through the ADD state; a lookup walks the slots in order until its pin is found.
// A movement step walks the table through one shared step unit, one result per channel;
// a transaction is accepted only while the sequencer is idle.
// Each slot takes a registered table read and an evaluate state, which waits while its result is stalled.
// Reset clears the channel count, the millisecond counter and step_interval (to 15);
// table contents stay undefined until a channel is added.
module multi_servo_slew_limiter_unit #(
   parameter int NUM_CHANNELS = msl_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [msl_pkg::OP_W-1:0]    req_op,
   input  logic [msl_pkg::PIN_W-1:0]   req_pin,
   input  logic [msl_pkg::POS_W-1:0]   req_position,
   input  logic [msl_pkg::SPD_W-1:0]   req_speed,
   input  logic [msl_pkg::POS_W-1:0]   req_limit_low,
   input  logic [msl_pkg::POS_W-1:0]   req_limit_high,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [msl_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [msl_pkg::PIN_W-1:0]   rsp_pin_tag,
   output logic [msl_pkg::POS_W-1:0]   rsp_current_position,
   output logic [msl_pkg::POS_W-1:0]   rsp_target_position,
   output logic [msl_pkg::STAT_W-1:0]  rsp_status,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [msl_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [msl_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [msl_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import msl_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [TIME_W-1:0] step_interval_ff, step_interval_in;

   logic [OP_W-1:0]   cmd_op_ff, cmd_op_in;
   logic [PIN_W-1:0]  cmd_pin_ff, cmd_pin_in;
   logic [POS_W-1:0]  cmd_position_ff, cmd_position_in;
   logic [SPD_W-1:0]  cmd_speed_ff, cmd_speed_in;
   logic [POS_W-1:0]  cmd_low_ff, cmd_low_in;
   logic [POS_W-1:0]  cmd_high_ff, cmd_high_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [PIN_W-1:0]  rsp_pin_ff, rsp_pin_in;
   logic [POS_W-1:0]  rsp_cur_ff, rsp_cur_in;
   logic [POS_W-1:0]  rsp_tgt_ff, rsp_tgt_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   entry_type         entry_mem [NUM_CHANNELS];
   entry_type         rd_data_ff;
   entry_type         wr_data;
   entry_type         upd_entry;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;

   logic [POS_W-1:0]  move_pos;
   logic              out_free;
   logic              is_last;
   logic              pin_hit;
   logic              pin_miss;
   logic              csr_write;
   logic [TIME_W-1:0] elapsed_inc;

   msl_move u_move (
      .entry        (rd_data_ff),
      .new_position (move_pos)
   );

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_pin_tag          = rsp_pin_ff;
   assign rsp_current_position = rsp_cur_ff;
   assign rsp_target_position  = rsp_tgt_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_last             = rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_STEP_INTERVAL) ? CSR_DW'(step_interval_ff) : '0;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign is_last     = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign pin_hit     = (count_ff != '0) && (rd_data_ff.pin == cmd_pin_ff);
   assign pin_miss    = !pin_hit && (is_last || (count_ff == '0));
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TIME_W'(1);

   always_comb begin
      upd_entry = rd_data_ff;
      case (cmd_op_ff)
         OP_SET_POS: begin
            upd_entry.position = cmd_position_ff;
            upd_entry.target   = cmd_position_ff;
         end
         OP_SET_TARGET: begin
            upd_entry.target = cmd_position_ff;
            upd_entry.speed  = cmd_speed_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      count_in         = count_ff;
      elapsed_in       = elapsed_ff;
      step_interval_in = step_interval_ff;
      cmd_op_in        = cmd_op_ff;
      cmd_pin_in       = cmd_pin_ff;
      cmd_position_in  = cmd_position_ff;
      cmd_speed_in     = cmd_speed_ff;
      cmd_low_in       = cmd_low_ff;
      cmd_high_in      = cmd_high_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_slot_in      = rsp_slot_ff;
      rsp_pin_in       = rsp_pin_ff;
      rsp_cur_in       = rsp_cur_ff;
      rsp_tgt_in       = rsp_tgt_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      wr_en            = 1'b0;
      wr_addr          = idx_ff;
      wr_data          = rd_data_ff;

      if (csr_write && (csr_paddr[2] == REG_STEP_INTERVAL)) begin
         step_interval_in = csr_pwdata[TIME_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_op_in       = req_op;
               cmd_pin_in      = req_pin;
               cmd_position_in = req_position;
               cmd_speed_in    = req_speed;
               cmd_low_in      = req_limit_low;
               cmd_high_in     = req_limit_high;
               idx_in          = '0;
               case (req_op)
                  OP_TICK: begin
                     elapsed_in = elapsed_inc;
                     if (elapsed_inc >= step_interval_ff) begin
                        elapsed_in = '0;
                        if (count_ff != '0) begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  OP_ADD: begin
                     state_in = ST_ADD;
                  end
                  OP_SET_POS, OP_SET_TARGET, OP_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pin_in   = cmd_pin_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (count_ff == CNT_W'(NUM_CHANNELS)) begin
                  rsp_slot_in   = '0;
                  rsp_cur_in    = '0;
                  rsp_tgt_in    = '0;
                  rsp_status_in = STATUS_FULL;
               end else begin
                  wr_en            = 1'b1;
                  wr_addr          = count_ff[IDX_W-1:0];
                  wr_data.pin      = cmd_pin_ff;
                  wr_data.position = cmd_low_ff;
                  wr_data.target   = cmd_low_ff;
                  wr_data.speed    = NEW_CHANNEL_SPEED;
                  wr_data.min      = cmd_low_ff;
                  wr_data.max      = cmd_high_ff;
                  rsp_slot_in      = SLOT_W'(count_ff);
                  rsp_cur_in       = cmd_low_ff;
                  rsp_tgt_in       = cmd_low_ff;
                  rsp_status_in    = STATUS_OK;
                  count_in         = count_ff + CNT_W'(1);
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (cmd_op_ff == OP_TICK) begin
               if (out_free) begin
                  wr_en            = 1'b1;
                  wr_data.position = move_pos;
                  rsp_valid_in     = 1'b1;
                  rsp_slot_in      = SLOT_W'(idx_ff);
                  rsp_pin_in       = rd_data_ff.pin;
                  rsp_cur_in       = move_pos;
                  rsp_tgt_in       = rd_data_ff.target;
                  rsp_status_in    = STATUS_OK;
                  rsp_last_in      = is_last;
                  if (is_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = ST_READ;
                  end
               end
            end else if (pin_hit) begin
               if (out_free) begin
                  wr_en         = (cmd_op_ff == OP_SET_POS) || (cmd_op_ff == OP_SET_TARGET);
                  wr_data       = upd_entry;
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = SLOT_W'(idx_ff);
                  rsp_pin_in    = upd_entry.pin;
                  rsp_cur_in    = upd_entry.position;
                  rsp_tgt_in    = upd_entry.target;
                  rsp_status_in = STATUS_OK;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (pin_miss) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_pin_in    = cmd_pin_ff;
                  rsp_cur_in    = '0;
                  rsp_tgt_in    = '0;
                  rsp_status_in = STATUS_NO_PIN;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         count_ff         <= '0;
         elapsed_ff       <= '0;
         step_interval_ff <= STEP_INTERVAL_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         elapsed_ff       <= elapsed_in;
         step_interval_ff <= step_interval_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      cmd_op_ff       <= cmd_op_in;
      cmd_pin_ff      <= cmd_pin_in;
      cmd_position_ff <= cmd_position_in;
      cmd_speed_ff    <= cmd_speed_in;
      cmd_low_ff      <= cmd_low_in;
      cmd_high_ff     <= cmd_high_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_pin_ff      <= rsp_pin_in;
      rsp_cur_ff      <= rsp_cur_in;
      rsp_tgt_ff      <= rsp_tgt_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[idx_ff];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_CHANNELS))
      else $error("Channel count exceeds the table size.");

   a_eval_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> ((CNT_W'(idx_ff) < count_ff) || (count_ff == '0)))
      else $error("Table walk is past the last channel.");

   a_count_only_on_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ADD) |=> (count_ff == $past(count_ff)))
      else $error("Channel count changed outside an add transaction.");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |->
         (rsp_last_ff && (rsp_cur_ff == '0) && (rsp_tgt_ff == '0) && (rsp_slot_ff == '0)))
      else $error("Error transaction carries channel data.");

endmodule
